// ===== hw/rtl/tsba_pkg.sv =====
// package: shared widths, codes and types for the touch soft-button area block
`timescale 1ns / 1ps

package tsba_pkg;

    localparam int COORD_W   = 16;
    localparam int SLOT_W    = 3;
    localparam int STATE_W   = 3;
    localparam int AREA_W    = 3;
    localparam int EV_W      = 4;
    localparam int TIMER_W   = 9;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_TOUCHES         = 8;
    localparam int DEF_ENTER_TIMEOUT_TICKS = 100;
    localparam int DEF_LEAVE_TIMEOUT_TICKS = 300;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [STATE_W-1:0] ST_NONE          = 3'd0;
    localparam logic [STATE_W-1:0] ST_AREA          = 3'd1;
    localparam logic [STATE_W-1:0] ST_BOTTOM        = 3'd2;
    localparam logic [STATE_W-1:0] ST_TOP           = 3'd3;
    localparam logic [STATE_W-1:0] ST_TOP_NEW       = 3'd4;
    localparam logic [STATE_W-1:0] ST_TOP_TO_IGNORE = 3'd5;
    localparam logic [STATE_W-1:0] ST_IGNORE        = 3'd6;

    localparam logic [AREA_W-1:0] AREA_NONE = 3'd0;
    localparam logic [AREA_W-1:0] AREA_MAIN = 3'd6;

    localparam logic [EV_W-1:0] EV_NONE    = 4'd0;
    localparam logic [EV_W-1:0] EV_BOT_R   = 4'd1;
    localparam logic [EV_W-1:0] EV_BOT_L   = 4'd2;
    localparam logic [EV_W-1:0] EV_TOP_R   = 4'd3;
    localparam logic [EV_W-1:0] EV_TOP_M   = 4'd4;
    localparam logic [EV_W-1:0] EV_TOP_L   = 4'd5;
    localparam logic [EV_W-1:0] EV_MAIN    = 4'd6;
    localparam logic [EV_W-1:0] EV_UP      = 4'd7;
    localparam logic [EV_W-1:0] EV_PRESS   = 4'd8;
    localparam logic [EV_W-1:0] EV_RELEASE = 4'd9;
    localparam logic [EV_W-1:0] EV_TIMEOUT = 4'd10;

    typedef struct packed {
        logic              tick;
        logic [SLOT_W-1:0] slot;
        logic [EV_W-1:0]   ev;
    } entry_t;

endpackage

// ===== hw/rtl/tsba_front.sv =====
// front end: configuration registers, input beat acceptance and area classification
`timescale 1ns / 1ps

module tsba_front
    import tsba_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_W-1:0]         cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 op,
    input  logic [SLOT_W-1:0]          touch_slot,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic                       q_full,
    output logic                       q_push,
    output entry_t                     q_entry
);

    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_AREA_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT_SPLIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_AREA_BOTTOM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT_SPLIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT_SPLIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_AREA_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_AREA_ENABLE    = 3'd6;

    localparam logic [2:0] OP_POS     = 3'd0;
    localparam logic [2:0] OP_UP      = 3'd1;
    localparam logic [2:0] OP_PRESS   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    logic signed [COORD_W-1:0] bottom_area_top_reg;
    logic signed [COORD_W-1:0] bottom_right_split_reg;
    logic signed [COORD_W-1:0] top_area_bottom_reg;
    logic signed [COORD_W-1:0] top_right_split_reg;
    logic signed [COORD_W-1:0] top_left_split_reg;
    logic                      bottom_area_enable_reg;
    logic                      top_area_enable_reg;

    logic            in_bottom;
    logic            in_top;
    logic [EV_W-1:0] area_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_area_top_reg    <= '0;
            bottom_right_split_reg <= '0;
            top_area_bottom_reg    <= '0;
            top_right_split_reg    <= '0;
            top_left_split_reg     <= '0;
            bottom_area_enable_reg <= 1'b1;
            top_area_enable_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOTTOM_AREA_TOP:    bottom_area_top_reg    <= cfg_wdata;
                REG_BOTTOM_RIGHT_SPLIT: bottom_right_split_reg <= cfg_wdata;
                REG_TOP_AREA_BOTTOM:    top_area_bottom_reg    <= cfg_wdata;
                REG_TOP_RIGHT_SPLIT:    top_right_split_reg    <= cfg_wdata;
                REG_TOP_LEFT_SPLIT:     top_left_split_reg     <= cfg_wdata;
                REG_BOTTOM_AREA_ENABLE: bottom_area_enable_reg <= cfg_wdata[0];
                REG_TOP_AREA_ENABLE:    top_area_enable_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // priority: bottom strip first, then top strip, else main area
    always_comb
    begin
        in_bottom = bottom_area_enable_reg && (pos_y >= bottom_area_top_reg);
        in_top    = top_area_enable_reg && (pos_y <= top_area_bottom_reg);
        if (in_bottom && (pos_x > bottom_right_split_reg))
            area_ev = EV_BOT_R;
        else if (in_bottom)
            area_ev = EV_BOT_L;
        else if (in_top && (pos_x > top_right_split_reg))
            area_ev = EV_TOP_R;
        else if (in_top && (pos_x >= top_left_split_reg))
            area_ev = EV_TOP_M;
        else if (in_top)
            area_ev = EV_TOP_L;
        else
            area_ev = EV_MAIN;
    end

    always_comb
    begin
        q_entry.tick = 1'b0;
        q_entry.slot = touch_slot;
        case (op)
            OP_POS:     q_entry.ev = area_ev;
            OP_UP:      q_entry.ev = EV_UP;
            OP_PRESS:   q_entry.ev = EV_PRESS;
            OP_RELEASE: q_entry.ev = EV_RELEASE;
            OP_TICK:
            begin
                q_entry.ev   = EV_NONE;
                q_entry.tick = 1'b1;
            end
            default:    q_entry.ev = EV_NONE;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/tsba_queue.sv =====
// short event queue between the classifier and the slot state machines
`timescale 1ns / 1ps

module tsba_queue
    import tsba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   nonempty,
    output entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/tsba_back.sv =====
// back end: per-slot state machines, timers and the output register
`timescale 1ns / 1ps

module tsba_back
    import tsba_pkg::*;
#(
    parameter int MAX_TOUCHES         = DEF_MAX_TOUCHES,
    parameter int ENTER_TIMEOUT_TICKS = DEF_ENTER_TIMEOUT_TICKS,
    parameter int LEAVE_TIMEOUT_TICKS = DEF_LEAVE_TIMEOUT_TICKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  entry_t              q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [STATE_W-1:0]  slot_state,
    output logic [AREA_W-1:0]   button_area,
    output logic                in_main_area,
    output logic                state_changed,
    output logic [MASK_W-1:0]   timeout_mask
);

    localparam int IDX_W = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;

    typedef struct packed {
        logic               enter;
        logic [STATE_W-1:0] st;
        logic [AREA_W-1:0]  area;
    } step_t;

    function automatic step_t fsm_step(input logic [STATE_W-1:0] st,
                                       input logic [AREA_W-1:0]  held,
                                       input logic [EV_W-1:0]    ev);
        step_t r;
        logic  is_bot;
        logic  is_top;
        logic  is_main;
        logic  same;
        is_bot  = ev inside {EV_BOT_R, EV_BOT_L};
        is_top  = ev inside {EV_TOP_R, EV_TOP_M, EV_TOP_L};
        is_main = (ev == EV_MAIN);
        same    = (ev == {1'b0, held});
        r.enter = 1'b0;
        r.st    = st;
        if (ev == EV_UP)
        begin
            r.enter = 1'b1;
            r.st    = ST_NONE;
        end
        else
        begin
            case (st)
                ST_NONE:
                begin
                    if (is_bot)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_BOTTOM;
                    end
                    else if (is_top)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_TOP_NEW;
                    end
                    else if (is_main)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_AREA;
                    end
                end
                ST_BOTTOM:
                begin
                    if (is_bot)
                    begin
                        r.enter = !same;
                    end
                    else if (is_top || is_main)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_AREA;
                    end
                end
                ST_TOP:
                begin
                    if (is_bot || is_main)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_TOP_TO_IGNORE;
                    end
                    else if (is_top && !same)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_TOP_NEW;
                    end
                end
                ST_TOP_NEW:
                begin
                    if (is_bot || is_main)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_AREA;
                    end
                    else if (is_top)
                    begin
                        r.enter = !same;
                    end
                    else if (ev == EV_PRESS || ev == EV_TIMEOUT)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_TOP;
                    end
                end
                ST_TOP_TO_IGNORE:
                begin
                    if (is_top)
                    begin
                        r.enter = 1'b1;
                        r.st    = same ? ST_TOP : ST_TOP_NEW;
                    end
                    else if (ev == EV_TIMEOUT)
                    begin
                        r.enter = 1'b1;
                        r.st    = ST_IGNORE;
                    end
                end
                default: ;
            endcase
        end
        case (r.st)
            ST_NONE:    r.area = AREA_NONE;
            ST_AREA:    r.area = AREA_MAIN;
            ST_BOTTOM:  r.area = ev[AREA_W-1:0];
            ST_TOP_NEW: r.area = ev[AREA_W-1:0];
            ST_IGNORE:  r.area = AREA_NONE;
            default:    r.area = held;
        endcase
        return r;
    endfunction

    logic [STATE_W-1:0] st_reg    [MAX_TOUCHES];
    logic [STATE_W-1:0] st_next   [MAX_TOUCHES];
    logic [AREA_W-1:0]  area_reg  [MAX_TOUCHES];
    logic [AREA_W-1:0]  area_next [MAX_TOUCHES];
    logic [TIMER_W-1:0] timer_reg [MAX_TOUCHES];
    logic [TIMER_W-1:0] timer_next[MAX_TOUCHES];
    step_t              step      [MAX_TOUCHES];
    logic [MAX_TOUCHES-1:0] expired;

    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [STATE_W-1:0] slot_state_reg;
    logic [AREA_W-1:0]  button_area_reg;
    logic               in_main_area_reg;
    logic               state_changed_reg;
    logic [MASK_W-1:0]  timeout_mask_reg;

    logic               slot_ok;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] rep_st;
    logic [AREA_W-1:0]  rep_area;
    logic               rep_changed;

    assign q_pop   = q_nonempty && (!out_valid_reg || out_ready);
    assign slot_ok = (int'(q_head.slot) < MAX_TOUCHES);
    assign idx     = IDX_W'(q_head.slot);

    always_comb
    begin
        for (int i = 0; i < MAX_TOUCHES; i++)
        begin
            expired[i] = q_head.tick && (timer_reg[i] == TIMER_W'(1));
            step[i]    = fsm_step(st_reg[i], area_reg[i],
                                  q_head.tick ? EV_TIMEOUT : q_head.ev);
            st_next[i]    = st_reg[i];
            area_next[i]  = area_reg[i];
            timer_next[i] = timer_reg[i];
            if (q_head.tick && (timer_reg[i] != '0))
                timer_next[i] = timer_reg[i] - 1'b1;
            if ((q_head.tick ? expired[i] : (slot_ok && (idx == IDX_W'(i))))
                && step[i].enter)
            begin
                st_next[i]   = step[i].st;
                area_next[i] = step[i].area;
                if (step[i].st == ST_TOP_NEW)
                    timer_next[i] = TIMER_W'(ENTER_TIMEOUT_TICKS);
                else if (step[i].st == ST_TOP_TO_IGNORE)
                    timer_next[i] = TIMER_W'(LEAVE_TIMEOUT_TICKS);
                else
                    timer_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        rep_st      = slot_ok ? st_next[idx] : ST_NONE;
        rep_area    = slot_ok ? area_next[idx] : AREA_NONE;
        rep_changed = slot_ok && (st_next[idx] != st_reg[idx]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TOUCHES; i++)
            begin
                st_reg[i]    <= ST_NONE;
                area_reg[i]  <= AREA_NONE;
                timer_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                for (int i = 0; i < MAX_TOUCHES; i++)
                begin
                    st_reg[i]    <= st_next[i];
                    area_reg[i]  <= area_next[i];
                    timer_reg[i] <= timer_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_slot_reg      <= q_head.slot;
            slot_state_reg    <= rep_st;
            button_area_reg   <= rep_area;
            in_main_area_reg  <= (rep_st == ST_AREA);
            state_changed_reg <= rep_changed;
            timeout_mask_reg  <= MASK_W'(expired);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_slot      = out_slot_reg;
    assign slot_state    = slot_state_reg;
    assign button_area   = button_area_reg;
    assign in_main_area  = in_main_area_reg;
    assign state_changed = state_changed_reg;
    assign timeout_mask  = timeout_mask_reg;

endmodule

// ===== hw/rtl/touch_softbutton_area_fsm.sv =====
// top level: touch soft-button area state machines, one per touch slot
//
// input channel (in_valid/in_ready): one beat is an op with a touch slot and
// a position; position beats are classified into bottom, top or main areas.
// output channel (out_valid/out_ready): exactly one result beat per input beat,
// in order, giving the reported slot's state, held area and the tick's
// timeout mask.
// configuration: cfg_we writes cfg_wdata into register cfg_index at once;
// write only while no beat is in flight.
// flow: a beat accepted at one clock edge is classified into the queue at
// that edge, and its result enters the output register when the back end
// pops it from the queue.
// throughput: one beat per cycle while out_ready stays high, as one
// combinational slot update evaluates all slot machines and timers in parallel.
// stall: the output register holds its beat while out_ready is low; the
// two-entry queue absorbs in-flight beats, and in_ready drops when it fills.
// reset: every slot goes to none with no area and an idle timer; the edge
// registers clear to 0, bottom strip enabled, top strip disabled.
`timescale 1ns / 1ps

module touch_softbutton_area_fsm
    import tsba_pkg::*;
#(
    parameter int MAX_TOUCHES         = DEF_MAX_TOUCHES,
    parameter int ENTER_TIMEOUT_TICKS = DEF_ENTER_TIMEOUT_TICKS,
    parameter int LEAVE_TIMEOUT_TICKS = DEF_LEAVE_TIMEOUT_TICKS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_W-1:0]         cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 op,
    input  logic [SLOT_W-1:0]          touch_slot,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SLOT_W-1:0]          out_slot,
    output logic [STATE_W-1:0]         slot_state,
    output logic [AREA_W-1:0]          button_area,
    output logic                       in_main_area,
    output logic                       state_changed,
    output logic [MASK_W-1:0]          timeout_mask
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_nonempty;
    entry_t q_in;
    entry_t q_head;

    tsba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .touch_slot (touch_slot),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    tsba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    tsba_back #(
        .MAX_TOUCHES         (MAX_TOUCHES),
        .ENTER_TIMEOUT_TICKS (ENTER_TIMEOUT_TICKS),
        .LEAVE_TIMEOUT_TICKS (LEAVE_TIMEOUT_TICKS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nonempty    (q_nonempty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_slot      (out_slot),
        .slot_state    (slot_state),
        .button_area   (button_area),
        .in_main_area  (in_main_area),
        .state_changed (state_changed),
        .timeout_mask  (timeout_mask)
    );

`ifndef SYNTHESIS
    a_main_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_main_area == (slot_state == ST_AREA)))
        else $error("in_main_area disagrees with slot_state");

    a_area_main: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slot_state == ST_AREA) |-> (button_area == AREA_MAIN))
        else $error("area state without main area");

    a_none_area: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (slot_state == ST_NONE || slot_state == ST_IGNORE))
        |-> (button_area == AREA_NONE))
        else $error("none or ignore state holds an area");

    a_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !q_pop)
        else $error("queue popped while output beat stalled");
`endif

endmodule

// ===== sim/tsba_test_pkg.sv =====
// package: op codes and register indexes shared by the soft-button area testbench
`timescale 1ns / 1ps

package tsba_test_pkg;

    import tsba_pkg::*;

    localparam logic [2:0] OP_POSITION   = 3'd0;
    localparam logic [2:0] OP_UP         = 3'd1;
    localparam logic [2:0] OP_PRESS      = 3'd2;
    localparam logic [2:0] OP_RELEASE    = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_BOT_STRIP_Y = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOT_SPLIT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_STRIP_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOT_ENABLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ENABLE  = 3'd6;

endpackage

// ===== sim/tsba_checker.sv =====
// checker: tracks every slot's button machine and compares each result beat in order
`timescale 1ns / 1ps

module tsba_checker
    import tsba_pkg::*;
    import tsba_test_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [2:0]                op,
    input  logic [SLOT_W-1:0]         touch_slot,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [SLOT_W-1:0]         out_slot,
    input  logic [STATE_W-1:0]        slot_state,
    input  logic [AREA_W-1:0]         button_area,
    input  logic                      in_main_area,
    input  logic                      state_changed,
    input  logic [MASK_W-1:0]         timeout_mask,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [STATE_W-1:0] state;
        logic [AREA_W-1:0]  area;
        logic               in_main;
        logic               changed;
        logic [MASK_W-1:0]  mask;
    } slot_report_t;

    logic signed [COORD_W-1:0] bot_strip_y;
    logic signed [COORD_W-1:0] bot_split_x;
    logic signed [COORD_W-1:0] top_strip_y;
    logic signed [COORD_W-1:0] top_right_x;
    logic signed [COORD_W-1:0] top_left_x;
    logic                      bot_en;
    logic                      top_en;

    logic [STATE_W-1:0] pad_state [DEF_MAX_TOUCHES];
    logic [AREA_W-1:0]  pad_area  [DEF_MAX_TOUCHES];
    logic [TIMER_W-1:0] pad_timer [DEF_MAX_TOUCHES];

    slot_report_t slot_reports_q [$];
    slot_report_t want;

    function automatic void enter_pad_state(input int s, input logic [STATE_W-1:0] target,
                                            input logic [EV_W-1:0] ev);
        pad_timer[s] = '0;
        pad_state[s] = target;
        case (target)
            ST_NONE, ST_IGNORE: pad_area[s] = AREA_NONE;
            ST_AREA:            pad_area[s] = AREA_MAIN;
            ST_BOTTOM:          pad_area[s] = ev[AREA_W-1:0];
            ST_TOP_NEW:
            begin
                pad_area[s]  = ev[AREA_W-1:0];
                pad_timer[s] = TIMER_W'(DEF_ENTER_TIMEOUT_TICKS);
            end
            ST_TOP_TO_IGNORE: pad_timer[s] = TIMER_W'(DEF_LEAVE_TIMEOUT_TICKS);
            default: ;
        endcase
    endfunction

    function automatic void apply_touch_event(input int s, input logic [EV_W-1:0] ev);
        logic is_bot;
        logic is_top;
        logic same;
        is_bot = (ev == EV_BOT_R) || (ev == EV_BOT_L);
        is_top = (ev == EV_TOP_R) || (ev == EV_TOP_M) || (ev == EV_TOP_L);
        same   = (ev == {1'b0, pad_area[s]});
        if (ev == EV_UP)
        begin
            enter_pad_state(s, ST_NONE, ev);
            return;
        end
        case (pad_state[s])
            ST_NONE:
            begin
                if (is_bot)
                    enter_pad_state(s, ST_BOTTOM, ev);
                else if (is_top)
                    enter_pad_state(s, ST_TOP_NEW, ev);
                else if (ev == EV_MAIN)
                    enter_pad_state(s, ST_AREA, ev);
            end
            ST_BOTTOM:
            begin
                if (is_bot)
                begin
                    if (!same)
                        enter_pad_state(s, ST_BOTTOM, ev);
                end
                else if (is_top || ev == EV_MAIN)
                    enter_pad_state(s, ST_AREA, ev);
            end
            ST_TOP:
            begin
                if (is_bot || ev == EV_MAIN)
                    enter_pad_state(s, ST_TOP_TO_IGNORE, ev);
                else if (is_top && !same)
                    enter_pad_state(s, ST_TOP_NEW, ev);
            end
            ST_TOP_NEW:
            begin
                if (is_bot || ev == EV_MAIN)
                    enter_pad_state(s, ST_AREA, ev);
                else if (is_top)
                begin
                    if (!same)
                        enter_pad_state(s, ST_TOP_NEW, ev);
                end
                else if (ev == EV_PRESS || ev == EV_TIMEOUT)
                    enter_pad_state(s, ST_TOP, ev);
            end
            ST_TOP_TO_IGNORE:
            begin
                if (is_top)
                    enter_pad_state(s, same ? ST_TOP : ST_TOP_NEW, ev);
                else if (ev == EV_TIMEOUT)
                    enter_pad_state(s, ST_IGNORE, ev);
            end
            default: ;
        endcase
    endfunction

    function automatic slot_report_t predict_report(input logic [2:0] opc,
                                                    input logic [SLOT_W-1:0] s,
                                                    input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        slot_report_t r;
        logic [STATE_W-1:0] prior;
        logic [MASK_W-1:0] expired;
        logic [EV_W-1:0] where;
        logic in_bot;
        logic in_top;
        int i;
        prior   = pad_state[s];
        expired = '0;
        if (opc == OP_TICK)
        begin
            for (i = 0; i < DEF_MAX_TOUCHES; i++)
            begin
                if (pad_timer[i] != 0)
                begin
                    pad_timer[i] = pad_timer[i] - 1'b1;
                    if (pad_timer[i] == 0)
                    begin
                        if (i < MASK_W)
                            expired[i] = 1'b1;
                        apply_touch_event(i, EV_TIMEOUT);
                    end
                end
            end
        end
        else
        begin
            case (opc)
                OP_POSITION:
                begin
                    // bottom strip wins over top strip, then right before middle before left
                    in_bot = bot_en && (y >= bot_strip_y);
                    in_top = top_en && (y <= top_strip_y);
                    if (in_bot && x > bot_split_x)
                        where = EV_BOT_R;
                    else if (in_bot)
                        where = EV_BOT_L;
                    else if (in_top && x > top_right_x)
                        where = EV_TOP_R;
                    else if (in_top && x >= top_left_x && x <= top_right_x)
                        where = EV_TOP_M;
                    else if (in_top && x < top_left_x)
                        where = EV_TOP_L;
                    else
                        where = EV_MAIN;
                    apply_touch_event(s, where);
                end
                OP_UP:      apply_touch_event(s, EV_UP);
                OP_PRESS:   apply_touch_event(s, EV_PRESS);
                OP_RELEASE: apply_touch_event(s, EV_RELEASE);
                default: ;
            endcase
        end
        r.slot    = s;
        r.state   = pad_state[s];
        r.area    = pad_area[s];
        r.in_main = (pad_state[s] == ST_AREA);
        r.changed = (pad_state[s] != prior);
        r.mask    = expired;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bot_strip_y = '0;
            bot_split_x = '0;
            top_strip_y = '0;
            top_right_x = '0;
            top_left_x  = '0;
            bot_en      = 1'b1;
            top_en      = 1'b0;
            for (int i = 0; i < DEF_MAX_TOUCHES; i++)
            begin
                pad_state[i] = ST_NONE;
                pad_area[i]  = AREA_NONE;
                pad_timer[i] = '0;
            end
            slot_reports_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (slot_reports_q.size() == 0)
                begin
                    $error("result beat for slot %0d with nothing outstanding", out_slot);
                    fail_count++;
                end
                else
                begin
                    want = slot_reports_q.pop_front();
                    check_field("out_slot", want.slot, out_slot);
                    check_field("slot_state", want.state, slot_state);
                    check_field("button_area", want.area, button_area);
                    check_field("in_main_area", want.in_main, in_main_area);
                    check_field("state_changed", want.changed, state_changed);
                    check_field("timeout_mask", want.mask, timeout_mask);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOT_STRIP_Y: bot_strip_y = cfg_wdata;
                    REG_BOT_SPLIT_X: bot_split_x = cfg_wdata;
                    REG_TOP_STRIP_Y: top_strip_y = cfg_wdata;
                    REG_TOP_RIGHT_X: top_right_x = cfg_wdata;
                    REG_TOP_LEFT_X:  top_left_x  = cfg_wdata;
                    REG_BOT_ENABLE:  bot_en      = cfg_wdata[0];
                    REG_TOP_ENABLE:  top_en      = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                slot_reports_q.push_back(predict_report(op, touch_slot, pos_x, pos_y));
            pending = slot_reports_q.size();
        end
    end

endmodule

// ===== sim/touch_softbutton_area_fsm_test.sv =====
// testbench top: drives touch gestures, ticks and edge settings into the soft-button block
`timescale 1ns / 1ps

module touch_softbutton_area_fsm_test
    import tsba_pkg::*;
    import tsba_test_pkg::*;
();

    localparam int PHASE_ITEMS = 120;
    localparam int CALM_FIRST  = 380;
    localparam int CALM_LAST   = 500;
    localparam int CYCLE_LIMIT = 300000;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index  = '0;
    logic [COORD_W-1:0]        cfg_wdata  = '0;
    logic                      in_valid   = 1'b0;
    logic [2:0]                op         = '0;
    logic [SLOT_W-1:0]         touch_slot = '0;
    logic signed [COORD_W-1:0] pos_x      = '0;
    logic signed [COORD_W-1:0] pos_y      = '0;
    logic                      out_ready  = 1'b0;
    logic                      in_ready;
    logic                      out_valid;
    logic [SLOT_W-1:0]         out_slot;
    logic [STATE_W-1:0]        slot_state;
    logic [AREA_W-1:0]         button_area;
    logic                      in_main_area;
    logic                      state_changed;
    logic [MASK_W-1:0]         timeout_mask;

    int fail_count;
    int pending;
    int sent   = 0;
    int cycles = 0;

    logic signed [COORD_W-1:0] geo_bot_y;
    logic signed [COORD_W-1:0] geo_bot_split;
    logic signed [COORD_W-1:0] geo_top_y;
    logic signed [COORD_W-1:0] geo_top_right;
    logic signed [COORD_W-1:0] geo_top_left;

    touch_softbutton_area_fsm i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .touch_slot    (touch_slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_slot      (out_slot),
        .slot_state    (slot_state),
        .button_area   (button_area),
        .in_main_area  (in_main_area),
        .state_changed (state_changed),
        .timeout_mask  (timeout_mask)
    );

    tsba_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .touch_slot    (touch_slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_slot      (out_slot),
        .slot_state    (slot_state),
        .button_area   (button_area),
        .in_main_area  (in_main_area),
        .state_changed (state_changed),
        .timeout_mask  (timeout_mask),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        out_ready <= (sent >= CALM_FIRST && sent < CALM_LAST) || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** touch_softbutton_area_fsm: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] e);
        return clamp_coord(int'(e) + int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_y();
        case ($urandom_range(0, 4))
            0:       return near(geo_bot_y);
            1:       return near(geo_top_y);
            2:       return 16'($urandom);
            3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return near($urandom_range(0, 1) ? geo_bot_y : geo_top_y);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_x();
        case ($urandom_range(0, 5))
            0:       return near(geo_bot_split);
            1:       return near(geo_top_right);
            2:       return near(geo_top_left);
            3:       return clamp_coord((int'(geo_top_left) + int'(geo_top_right)) / 2);
            4:       return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // called at a rising edge, returns at the edge where the beat is taken
    task automatic send_item(input logic [2:0] opc, input logic [SLOT_W-1:0] s,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        if (!(sent >= CALM_FIRST && sent < CALM_LAST) && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= opc;
        touch_slot <= s;
        pos_x      <= x;
        pos_y      <= y;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    // tick runs stop once the phase has its share of beats
    task automatic send_ticks(input int n, input int limit);
        repeat (n)
        begin
            if (sent < limit)
                send_item(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic signed [COORD_W-1:0] bot_y,
                                input logic signed [COORD_W-1:0] bot_split,
                                input logic signed [COORD_W-1:0] top_y,
                                input logic signed [COORD_W-1:0] top_right,
                                input logic signed [COORD_W-1:0] top_left,
                                input logic bot_on, input logic top_on);
        quiesce();
        geo_bot_y     = bot_y;
        geo_bot_split = bot_split;
        geo_top_y     = top_y;
        geo_top_right = top_right;
        geo_top_left  = top_left;
        write_reg(REG_BOT_STRIP_Y, bot_y);
        write_reg(REG_BOT_SPLIT_X, bot_split);
        write_reg(REG_TOP_STRIP_Y, top_y);
        write_reg(REG_TOP_RIGHT_X, top_right);
        write_reg(REG_TOP_LEFT_X, top_left);
        write_reg(REG_BOT_ENABLE, {15'b0, bot_on});
        write_reg(REG_TOP_ENABLE, {15'b0, top_on});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly gestures on one slot with random content, the rest noise, ticks and lone up beats
    task automatic run_random(input int n);
        int target;
        int pick;
        logic [SLOT_W-1:0] s;
        target = sent + n;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            s    = 3'($urandom);
            if (pick < 60)
            begin
                repeat ($urandom_range(2, 9))
                begin
                    pick = $urandom_range(0, 199);
                    if (pick < 100)
                        send_item(OP_POSITION, s, pick_x(), pick_y());
                    else if (pick < 124)
                        send_item(OP_PRESS, s, 16'($urandom), 16'($urandom));
                    else if (pick < 140)
                        send_item(OP_RELEASE, s, 16'($urandom), 16'($urandom));
                    else if (pick < 188)
                        send_ticks($urandom_range(1, 12), target);
                    else if (pick < 196)
                        send_ticks($urandom_range(95, 105), target);
                    else
                        send_ticks($urandom_range(295, 305), target);
                end
                if ($urandom_range(0, 99) < 65)
                    send_item(OP_UP, s, 16'($urandom), 16'($urandom));
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(3'($urandom), 3'($urandom), pick_x(), pick_y());
            end
            else if (pick < 92)
                send_ticks($urandom_range(1, 10), target);
            else
                send_item(OP_UP, s, 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(16'sd1000, 16'sd0, -16'sd1000, 16'sd500, -16'sd500, 1'b1, 1'b1);
        // bottom entry, bottom to bottom re-entry, same bottom area, then main and up
        send_item(OP_POSITION, 3'd0, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_POSITION, 3'd0, 16'sh8000, 16'sd1000);
        send_item(OP_POSITION, 3'd0, -16'sd100, 16'sd2000);
        send_item(OP_POSITION, 3'd0, 16'sd0, 16'sd0);
        send_item(OP_UP, 3'd0, 16'sd0, 16'sd0);
        // top buttons: top-new re-entry, press, leave and come back
        send_item(OP_POSITION, 3'd1, 16'sd600, 16'sh8000);
        send_item(OP_POSITION, 3'd1, -16'sd500, -16'sd1000);
        send_item(OP_PRESS, 3'd1, 16'sd0, 16'sd0);
        send_item(OP_POSITION, 3'd1, 16'sh8000, -16'sd1000);
        send_item(OP_RELEASE, 3'd1, 16'sd0, 16'sd0);
        send_item(OP_PRESS, 3'd1, 16'sd0, 16'sd0);
        send_item(OP_POSITION, 3'd1, 16'sd0, 16'sd0);
        send_item(OP_POSITION, 3'd1, -16'sd600, -16'sd2000);
        send_item(OP_POSITION, 3'd1, 16'sd0, 16'sd999);
        send_item(OP_POSITION, 3'd1, 16'sd500, -16'sd1000);
        // main area ignores strips and buttons
        send_item(OP_POSITION, 3'd2, 16'sd0, 16'sd0);
        send_item(OP_POSITION, 3'd2, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_PRESS, 3'd2, 16'sd0, 16'sd0);
        for (r = OP_RSVD_FIRST; r <= OP_RSVD_LAST; r++)
            send_item(3'(r), 3'd3, 16'sh5555, 16'shAAAA);
        send_item(OP_POSITION, 3'd7, 16'sd0, -16'sd1000);
        send_item(OP_TICK, 3'd5, 16'shAAAA, 16'sh5555);
        send_item(OP_UP, 3'd7, 16'sd0, 16'sd0);
        run_random(PHASE_ITEMS);

        set_geometry(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
        run_random(PHASE_ITEMS);

        set_geometry(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
        run_random(PHASE_ITEMS);

        // left split above right split
        set_geometry(16'($urandom), 16'($urandom), 16'($urandom), -16'sd1000, 16'sd1000,
                     1'b0, 1'b1);
        run_random(PHASE_ITEMS);

        set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'b0, 1'b0);
        run_random(PHASE_ITEMS);

        set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'($urandom), 1'($urandom));
        run_random(PHASE_ITEMS);

        quiesce();
        if (fail_count == 0)
            $display("** touch_softbutton_area_fsm: PASSED **");
        else
            $display("** touch_softbutton_area_fsm: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tsba_pkg.sv
hw/rtl/tsba_front.sv
hw/rtl/tsba_queue.sv
hw/rtl/tsba_back.sv
hw/rtl/touch_softbutton_area_fsm.sv
sim/tsba_test_pkg.sv
sim/tsba_checker.sv
sim/touch_softbutton_area_fsm_test.sv
